FILE: rtl/core/drpi_pkg.sv
// drpi_pkg: shared types, constants and the cordic arctangent table
// for the dead reckoning pose integrator; depends on nothing
package drpi_pkg;

  // default number of cordic iterations
  localparam int CORDIC_STEPS_DEF = 16;

  // cordic start value, gain 0.607252935 in q2.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // heading scale, about 2^56 / (2*pi*1e6)
  localparam logic [33:0] HDG_K = 34'd11468322278;

  // position step divisor: step = v * dt * 32 / 125000
  localparam logic [17:0] POS_DIV = 18'd125000;

  // position limits
  localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COR1,
    ST_MV,
    ST_MD,
    ST_DV,
    ST_MP,
    ST_MH,
    ST_COR2,
    ST_FIN
  } drpi_state_t;

  // arctangent of 2^-i as a binary angle
  function automatic logic [31:0] atan_ba(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/drpi_cordic.sv
// drpi_cordic: iterative rotation-mode cordic, binary angle in, q1.15 cos and sin out
// depends on drpi_pkg
module drpi_cordic #(
  parameter int STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [15:0] cos_q,
  output logic signed [15:0] sin_q
);
  import drpi_pkg::*;

  logic               busy_r, fin_r, done_r, flip_r;
  logic [5:0]         cnt_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic signed [15:0] cos_r, sin_r;
  logic [4:0]         k;
  logic signed [33:0] dx, dy, at;
  logic               fold;
  logic [31:0]        ang_f;

  // round q2.30 to q1.15 and saturate
  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [19:0] r;
    t = 35'(v) + 35'sd16384;
    r = 20'(t >>> 15);
    if (r > 20'sd32767) return 16'sh7FFF;
    if (r < -20'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  // fold angles outside [-pi/2, pi/2) by half a turn
  assign fold  = angle[31] ^ angle[30];
  assign ang_f = fold ? (angle ^ 32'h8000_0000) : angle;

  // one micro-rotation
  assign k  = cnt_r[4:0];
  assign dx = y_r >>> k;
  assign dy = x_r >>> k;
  assign at = {2'b00, atan_ba(k)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
        flip_r <= fold;
        x_r    <= CORDIC_GAIN;
        y_r    <= 34'sd0;
        z_r    <= {{2{ang_f[31]}}, ang_f};
      end else if (busy_r) begin
        if (!z_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        cos_r  <= to_q15(flip_r ? -x_r : x_r);
        sin_r  <= to_q15(flip_r ? -y_r : y_r);
      end
    end
  end

  assign done  = done_r;
  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

FILE: rtl/core/dead_reckoning_pose_integrator.sv
// dead_reckoning_pose_integrator: top level, sequencer, serial multiplier and divider
// depends on drpi_pkg and drpi_cordic
//
// Integrates velocity items into a pose. Each item goes through a sequencer that
// runs a cordic for the old heading, a shift-add multiplier one bit per cycle (twice
// per axis, then twice for the heading), a restoring divider by 125000 one quotient
// bit per cycle (once per axis) and a second cordic for the half heading. One item
// is in work at a time; the result sits in an output register, so the next item is
// taken while it waits.
module dead_reckoning_pose_integrator #(
  parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_linear_speed,
  input  logic signed [23:0] in_turn_rate,
  input  logic [31:0]        in_timestamp_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_pos_x,
  output logic signed [47:0] out_pos_y,
  output logic signed [31:0] out_heading,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic signed [23:0] out_speed_echo,
  output logic signed [23:0] out_rate_echo
);
  import drpi_pkg::*;

  drpi_state_t state_r, state_nxt;

  // pose state
  logic signed [47:0] x_r, y_r;
  logic [31:0]        hdg_r, last_r;
  logic               seen_r;

  // item registers
  logic signed [23:0] speed_r, rate_r;
  logic [31:0]        dt_r;
  logic signed [15:0] s_r;
  logic               axis_r, vneg_r;

  // serial multiplier
  logic [71:0] macc_r, ma_r;
  logic [33:0] mb_r;
  logic [5:0]  mcnt_r;
  logic        msgn_r;
  logic [71:0] maddend;

  // serial divider
  logic [60:0] dv_r;
  logic [16:0] rem_r;
  logic [5:0]  dcnt_r;
  logic [17:0] dtry;
  logic        dge;

  // output register
  logic               ovalid_r;
  logic signed [47:0] ox_r, oy_r;
  logic [31:0]        oh_r;
  logic signed [15:0] oz_r, ow_r;
  logic signed [23:0] ospd_r, orate_r;

  // cordic
  logic               cor_start;
  logic [31:0]        cor_ang;
  logic               cor_done;
  logic signed [15:0] cor_cos, cor_sin;

  // combinational helpers
  logic               accept, fin_go;
  logic signed [24:0] vfull;
  logic [24:0]        vmag;
  logic [44:0]        qmag;
  logic signed [48:0] pstep, psum;
  logic signed [47:0] psat, pcur;
  logic [31:0]        hnew;

  drpi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_ang),
    .done  (cor_done),
    .cos_q (cor_cos),
    .sin_q (cor_sin)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = (state_r == ST_FIN) && (!ovalid_r || out_ready);

  // multiplier step, last bit of a signed multiplier has negative weight
  assign maddend = !mb_r[0] ? 72'd0 :
                   ((mcnt_r == 6'd1) && msgn_r) ? (72'd0 - ma_r) : ma_r;

  // divider step
  assign dtry = {rem_r, dv_r[60]};
  assign dge  = (dtry >= POS_DIV);

  // velocity component from speed times cos or sin
  assign vfull = macc_r[39:15];
  assign vmag  = vfull[24] ? (25'd0 - vfull) : vfull;

  // position update with saturation
  assign qmag  = dv_r[44:0];
  assign pstep = vneg_r ? -$signed({4'b0, qmag}) : $signed({4'b0, qmag});
  assign pcur  = axis_r ? y_r : x_r;
  assign psum  = {pcur[47], pcur} + pstep;
  assign psat  = (psum[48] != psum[47]) ? (psum[48] ? POS_MIN : POS_MAX) : psum[47:0];

  // heading update
  assign hnew = hdg_r + macc_r[71:40];

  // cordic start points
  assign cor_start = accept || ((state_r == ST_MH) && (mcnt_r == 6'd0));
  assign cor_ang   = accept ? hdg_r : {hnew[31], hnew[31:1]};

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_COR1;
      ST_COR1: if (cor_done) state_nxt = ST_MV;
      ST_MV:   if (mcnt_r == 6'd0) state_nxt = ST_MD;
      ST_MD:   if (mcnt_r == 6'd0) state_nxt = ST_DV;
      ST_DV:   if (dcnt_r == 6'd0) state_nxt = axis_r ? ST_MP : ST_MV;
      ST_MP:   if (mcnt_r == 6'd0) state_nxt = ST_MH;
      ST_MH:   if (mcnt_r == 6'd0) state_nxt = ST_COR2;
      ST_COR2: if (cor_done) state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // pose state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r      <= 48'sd0;
      y_r      <= 48'sd0;
      hdg_r    <= 32'd0;
      last_r   <= 32'd0;
      seen_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (accept) begin
        last_r <= in_timestamp_us;
        seen_r <= 1'b1;
      end
      if ((state_r == ST_DV) && (dcnt_r == 6'd0)) begin
        if (axis_r) y_r <= psat;
        else        x_r <= psat;
      end
      if ((state_r == ST_MH) && (mcnt_r == 6'd0)) hdg_r <= hnew;
      if (fin_go)         ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= 6'd0;
      dcnt_r <= 6'd0;
    end else begin
      if (mcnt_r != 6'd0) begin
        macc_r <= macc_r + maddend;
        ma_r   <= {ma_r[70:0], 1'b0};
        mb_r   <= {1'b0, mb_r[33:1]};
        mcnt_r <= mcnt_r - 6'd1;
      end
      if (dcnt_r != 6'd0) begin
        rem_r  <= dge ? 17'(dtry - POS_DIV) : dtry[16:0];
        dv_r   <= {dv_r[59:0], dge};
        dcnt_r <= dcnt_r - 6'd1;
      end
      unique case (state_r)
        ST_IDLE: if (accept) begin
          speed_r <= in_linear_speed;
          rate_r  <= in_turn_rate;
          dt_r    <= seen_r ? (in_timestamp_us - last_r) : 32'd0;
          axis_r  <= 1'b0;
        end
        ST_COR1: if (cor_done) begin
          s_r    <= cor_sin;
          macc_r <= 72'd0;
          ma_r   <= 72'(speed_r);
          mb_r   <= {18'd0, cor_cos};
          msgn_r <= 1'b1;
          mcnt_r <= 6'd16;
        end
        ST_MV: if (mcnt_r == 6'd0) begin
          vneg_r <= vfull[24];
          macc_r <= 72'd0;
          ma_r   <= {47'd0, vmag};
          mb_r   <= {2'd0, dt_r};
          msgn_r <= 1'b0;
          mcnt_r <= 6'd32;
        end
        ST_MD: if (mcnt_r == 6'd0) begin
          dv_r   <= {macc_r[55:0], 5'd0};
          rem_r  <= 17'd0;
          dcnt_r <= 6'd61;
        end
        ST_DV: if (dcnt_r == 6'd0) begin
          macc_r <= 72'd0;
          mb_r   <= axis_r ? {2'd0, dt_r} : {18'd0, s_r};
          ma_r   <= axis_r ? 72'(rate_r) : 72'(speed_r);
          msgn_r <= !axis_r;
          mcnt_r <= axis_r ? 6'd32 : 6'd16;
          axis_r <= !axis_r;
        end
        ST_MP: if (mcnt_r == 6'd0) begin
          ma_r   <= 72'($signed(macc_r[55:0]));
          macc_r <= 72'd0;
          mb_r   <= HDG_K;
          msgn_r <= 1'b0;
          mcnt_r <= 6'd34;
        end
        // cordic outputs hold until the next item starts it again
        ST_FIN: if (fin_go) begin
          ox_r    <= x_r;
          oy_r    <= y_r;
          oh_r    <= hdg_r;
          ow_r    <= cor_cos;
          oz_r    <= cor_sin;
          ospd_r  <= speed_r;
          orate_r <= rate_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid      = ovalid_r;
  assign out_pos_x      = ox_r;
  assign out_pos_y      = oy_r;
  assign out_heading    = oh_r;
  assign out_quat_z     = oz_r;
  assign out_quat_w     = ow_r;
  assign out_speed_echo = ospd_r;
  assign out_rate_echo  = orate_r;

endmodule
